/* sv/csbs_pkg.sv */
// Shared types, constants and channel arithmetic for the cross-stencil blur and sharpen core.
package csbs_pkg;

    localparam int DIM_W      = 12;
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 2;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 12'd480;

    localparam logic ACT_PIXEL    = 1'b0;
    localparam logic ACT_FLUSH    = 1'b1;
    localparam logic MODE_BLUR    = 1'b0;
    localparam logic MODE_SHARPEN = 1'b1;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // Division by five as a multiplication by a scaled reciprocal; exact for sums up to 1275.
    localparam int              BLUR_SHIFT = 18;
    localparam logic [15:0]     BLUR_RECIP = 16'd52429;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_FILTER_MODE  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic pass;
        logic sharpen;
        logic frame_end;
    } t_emit_ctl;

    function automatic logic [CH_W-1:0] csbs_chan(
        input logic [CH_W-1:0] c,
        input logic [CH_W-1:0] u,
        input logic [CH_W-1:0] d,
        input logic [CH_W-1:0] l,
        input logic [CH_W-1:0] r,
        input logic            sharpen
    );
        logic [9:0]         s;
        logic [10:0]        tot;
        logic [26:0]        prod;
        logic [10:0]        five_c;
        logic signed [12:0] t;
        logic [CH_W-1:0]    res;
        s      = 10'(u) + 10'(d) + 10'(l) + 10'(r);
        tot    = 11'(c) + 11'(s);
        prod   = 27'(tot) * 27'(BLUR_RECIP);
        five_c = 11'({c, 2'b00}) + 11'(c);
        t      = $signed({2'b00, five_c}) - $signed({3'b000, s});
        if (sharpen == MODE_SHARPEN) begin
            if (t < 0) begin
                res = '0;
            end else if (t > 13'sd255) begin
                res = CH_MAX;
            end else begin
                res = t[CH_W-1:0];
            end
        end else begin
            res = prod[BLUR_SHIFT +: CH_W];
        end
        return res;
    endfunction

endpackage

/* sv/csbs_rem.sv */
// Serial restoring remainder unit that recomputes the output column after a width change.
module csbs_rem #(
    parameter int MAX_WIDTH  = csbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = csbs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_start,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0]      i_dividend,
    input  logic [csbs_pkg::DIM_W-1:0]                     i_divisor,
    output logic                                           o_busy,
    output logic                                           o_done,
    output logic [csbs_pkg::DIM_W-1:0]                     o_rem
);
    import csbs_pkg::*;

    localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int IDX_W = $clog2(CNT_W);

    logic               r_busy;
    logic [IDX_W-1:0]   r_bit;
    logic [DIM_W-1:0]   r_rem;
    logic [DIM_W:0]     trial;
    logic [DIM_W-1:0]   n_rem;

    always_comb begin
        trial = {r_rem, i_dividend[r_bit]};
        if (trial >= {1'b0, i_divisor}) begin
            n_rem = DIM_W'(trial - {1'b0, i_divisor});
        end else begin
            n_rem = DIM_W'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_bit  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_bit  <= IDX_W'(CNT_W - 1);
        end else if (r_busy) begin
            if (r_bit == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_bit <= r_bit - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_bit == '0) && !i_start;
    assign o_rem  = n_rem;

endmodule

/* sv/csbs_ctrl.sv */
// Configuration registers, frame counters, ring addressing and emit decision.
module csbs_ctrl #(
    parameter int MAX_WIDTH  = csbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = csbs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [csbs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [csbs_pkg::DIM_W-1:0]            i_cfg_wdata,
    input  logic                                  i_accept,
    input  logic                                  i_action,
    input  logic                                  i_out_free,
    output logic                                  o_stall,
    output logic                                  o_s1_valid,
    output csbs_pkg::t_emit_ctl                   o_s1_ctl,
    output logic                                  o_wr_en,
    output logic                                  o_rd_en,
    output logic [$clog2(2*MAX_WIDTH+1)-1:0]      o_wr_addr,
    output logic [$clog2(2*MAX_WIDTH+1)-1:0]      o_up_addr,
    output logic [$clog2(2*MAX_WIDTH+1)-1:0]      o_dn_addr,
    output logic [$clog2(2*MAX_WIDTH+1)-1:0]      o_ctr_addr,
    output logic [$clog2(2*MAX_WIDTH+1)-1:0]      o_rgt_addr
);
    import csbs_pkg::*;

    localparam int DEPTH = 2 * MAX_WIDTH + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int CMP_W = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 1;
    localparam logic [AW:0] DEPTH_X = (AW + 1)'(DEPTH);

    logic [DIM_W-1:0]   r_cfg_width;
    logic [DIM_W-1:0]   r_cfg_height;
    logic               r_cfg_mode;

    logic [CNT_W-1:0]   r_ic;
    logic [CNT_W-1:0]   r_oc;
    logic [AW-1:0]      r_wa;
    logic [AW-1:0]      r_pa;
    logic [DIM_W-1:0]   r_col;
    logic               r_s1_valid;
    t_emit_ctl          r_s1_ctl;

    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [2*DIM_W-1:0] area;
    logic [CNT_W-1:0]   total;
    logic               pix_ok;
    logic [CNT_W-1:0]   n_ic;
    logic               emit;
    logic               frame_end;
    logic               pass;
    logic [AW:0]        w_ring;
    logic [AW:0]        dn_sum;
    logic [AW:0]        up_sum;
    logic [AW-1:0]      n_wa;
    logic [AW-1:0]      n_pa;
    logic [DIM_W-1:0]   n_col;
    logic               rem_start;
    logic               rem_busy;
    logic               rem_done;
    logic [DIM_W-1:0]   rem_val;

    assign rem_start = i_cfg_wr_en && (t_cfg_idx'(i_cfg_index) == CFG_IMAGE_WIDTH);

    csbs_rem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_oc),
        .i_divisor  (w_eff),
        .o_busy     (rem_busy),
        .o_done     (rem_done),
        .o_rem      (rem_val)
    );

    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = r_cfg_width;
        end
        if (r_cfg_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (32'(r_cfg_height) > MAX_HEIGHT) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_cfg_height;
        end
    end

    always_comb begin
        area   = w_eff * h_eff;
        total  = CNT_W'(area);
        pix_ok = (i_action == ACT_PIXEL) && (r_ic < total);
        n_ic   = pix_ok ? r_ic + 1'b1 : r_ic;
        if (i_action == ACT_FLUSH) begin
            emit = r_oc < r_ic;
        end else begin
            emit = pix_ok && (CMP_W'(n_ic - r_oc) >= CMP_W'(w_eff) + CMP_W'(1));
        end
        frame_end = (CMP_W'(r_oc) + CMP_W'(1)) >= CMP_W'(total);
        pass = (CMP_W'(r_oc) < CMP_W'(w_eff))
            || ((CMP_W'(r_oc) + CMP_W'(w_eff)) >= CMP_W'(total))
            || (r_col == '0)
            || ({1'b0, r_col} + (DIM_W + 1)'(1) == {1'b0, w_eff})
            || ((CMP_W'(r_oc) + CMP_W'(w_eff)) >= CMP_W'(n_ic));

        w_ring = (AW + 1)'(w_eff);
        dn_sum = {1'b0, r_pa} + w_ring;
        up_sum = {1'b0, r_pa} + (DEPTH_X - w_ring);
        o_dn_addr  = (dn_sum >= DEPTH_X) ? AW'(dn_sum - DEPTH_X) : AW'(dn_sum);
        o_up_addr  = (up_sum >= DEPTH_X) ? AW'(up_sum - DEPTH_X) : AW'(up_sum);
        o_ctr_addr = r_pa;
        o_rgt_addr = (r_pa == AW'(DEPTH - 1)) ? '0 : r_pa + 1'b1;
        o_wr_addr  = r_wa;

        n_wa  = (r_wa == AW'(DEPTH - 1)) ? '0 : r_wa + 1'b1;
        n_pa  = o_rgt_addr;
        n_col = ({1'b0, r_col} + (DIM_W + 1)'(1) == {1'b0, w_eff}) ? '0 : r_col + 1'b1;
    end

    assign o_wr_en    = i_accept && pix_ok;
    assign o_rd_en    = i_accept;
    assign o_stall    = rem_busy || (r_s1_valid && !i_out_free);
    assign o_s1_valid = r_s1_valid;
    assign o_s1_ctl   = r_s1_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_IMAGE_WIDTH;
            r_cfg_height <= RST_IMAGE_HEIGHT;
            r_cfg_mode   <= MODE_BLUR;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH: begin
                    r_cfg_width <= i_cfg_wdata;
                end
                CFG_IMAGE_HEIGHT: begin
                    r_cfg_height <= i_cfg_wdata;
                end
                CFG_FILTER_MODE: begin
                    r_cfg_mode <= i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic       <= '0;
            r_oc       <= '0;
            r_wa       <= '0;
            r_pa       <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= (i_accept && emit) || (r_s1_valid && !i_out_free);
            if (rem_done) begin
                r_col <= rem_val;
            end
            if (i_accept) begin
                if (emit && frame_end) begin
                    r_ic  <= '0;
                    r_oc  <= '0;
                    r_wa  <= '0;
                    r_pa  <= '0;
                    r_col <= '0;
                end else begin
                    r_ic <= n_ic;
                    if (pix_ok) begin
                        r_wa <= n_wa;
                    end
                    if (emit) begin
                        r_oc  <= r_oc + 1'b1;
                        r_pa  <= n_pa;
                        r_col <= n_col;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && emit) begin
            r_s1_ctl.pass      <= pass;
            r_s1_ctl.sharpen   <= r_cfg_mode;
            r_s1_ctl.frame_end <= frame_end;
        end
    end

    a_out_behind_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oc <= r_ic)
        else $error("Output count has overtaken the input count.");

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !rem_busy |-> (r_col < w_eff))
        else $error("Output column lies outside the current row width.");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_ctl.frame_end) |->
            (r_ic == '0 && r_oc == '0 && r_wa == '0 && r_pa == '0))
        else $error("Counters not restarted after the last pixel of a frame.");

endmodule

/* sv/csbs_hist.sv */
// Pixel history memories with registered reads and same-cycle write forwarding.
module csbs_hist #(
    parameter int MAX_WIDTH = csbs_pkg::DEF_MAX_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_wr_en,
    input  logic [$clog2(2*MAX_WIDTH+1)-1:0]   i_wr_addr,
    input  logic [csbs_pkg::PIX_W-1:0]         i_wr_px,
    input  logic                               i_rd_en,
    input  logic [$clog2(2*MAX_WIDTH+1)-1:0]   i_up_addr,
    input  logic [$clog2(2*MAX_WIDTH+1)-1:0]   i_dn_addr,
    input  logic [$clog2(2*MAX_WIDTH+1)-1:0]   i_ctr_addr,
    input  logic [$clog2(2*MAX_WIDTH+1)-1:0]   i_rgt_addr,
    output logic [csbs_pkg::PIX_W-1:0]         o_up,
    output logic [csbs_pkg::PIX_W-1:0]         o_dn,
    output logic [csbs_pkg::PIX_W-1:0]         o_lf,
    output logic [csbs_pkg::PIX_W-1:0]         o_ctr,
    output logic [csbs_pkg::PIX_W-1:0]         o_rgt
);
    import csbs_pkg::*;

    localparam int DEPTH = 2 * MAX_WIDTH + 1;

    // The pair memory holds each pixel beside the one written just before it.
    logic [PIX_W-1:0]   r_mem_px   [DEPTH];
    logic [2*PIX_W-1:0] r_mem_pair [DEPTH];

    logic [PIX_W-1:0]   r_last_px;
    logic [PIX_W-1:0]   r_up_raw;
    logic [PIX_W-1:0]   r_dn_raw;
    logic [2*PIX_W-1:0] r_ctr_raw;
    logic [PIX_W-1:0]   r_rgt_raw;
    logic               r_up_fwd;
    logic               r_dn_fwd;
    logic               r_ctr_fwd;
    logic               r_rgt_fwd;
    logic [PIX_W-1:0]   r_fwd_px;
    logic [PIX_W-1:0]   r_fwd_last;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_px[i_wr_addr]   <= i_wr_px;
            r_mem_pair[i_wr_addr] <= {i_wr_px, r_last_px};
            r_last_px             <= i_wr_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up_raw   <= r_mem_px[i_up_addr];
            r_dn_raw   <= r_mem_px[i_dn_addr];
            r_ctr_raw  <= r_mem_pair[i_ctr_addr];
            r_rgt_raw  <= r_mem_pair[i_rgt_addr][2*PIX_W-1:PIX_W];
            r_up_fwd   <= i_wr_en && (i_up_addr == i_wr_addr);
            r_dn_fwd   <= i_wr_en && (i_dn_addr == i_wr_addr);
            r_ctr_fwd  <= i_wr_en && (i_ctr_addr == i_wr_addr);
            r_rgt_fwd  <= i_wr_en && (i_rgt_addr == i_wr_addr);
            r_fwd_px   <= i_wr_px;
            r_fwd_last <= r_last_px;
        end
    end

    assign o_up  = r_up_fwd  ? r_fwd_px   : r_up_raw;
    assign o_dn  = r_dn_fwd  ? r_fwd_px   : r_dn_raw;
    assign o_ctr = r_ctr_fwd ? r_fwd_px   : r_ctr_raw[2*PIX_W-1:PIX_W];
    assign o_lf  = r_ctr_fwd ? r_fwd_last : r_ctr_raw[PIX_W-1:0];
    assign o_rgt = r_rgt_fwd ? r_fwd_px   : r_rgt_raw;

endmodule

/* sv/csbs_alu.sv */
// Per-channel blur or sharpen arithmetic and the output register.
module csbs_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s1_valid,
    input  csbs_pkg::t_emit_ctl           i_s1_ctl,
    input  logic [csbs_pkg::PIX_W-1:0]    i_up,
    input  logic [csbs_pkg::PIX_W-1:0]    i_dn,
    input  logic [csbs_pkg::PIX_W-1:0]    i_lf,
    input  logic [csbs_pkg::PIX_W-1:0]    i_ctr,
    input  logic [csbs_pkg::PIX_W-1:0]    i_rgt,
    input  logic                          i_out_free,
    output logic                          o_valid,
    output logic [csbs_pkg::PIX_W-1:0]    o_out_rgb,
    output logic                          o_frame_end
);
    import csbs_pkg::*;

    logic               r_valid;
    logic [PIX_W-1:0]   r_rgb;
    logic               r_frame_end;
    logic [PIX_W-1:0]   n_rgb;

    always_comb begin
        if (i_s1_ctl.pass) begin
            n_rgb = i_ctr;
        end else begin
            n_rgb[23:16] = csbs_chan(i_ctr[23:16], i_up[23:16], i_dn[23:16],
                                     i_lf[23:16], i_rgt[23:16], i_s1_ctl.sharpen);
            n_rgb[15:8]  = csbs_chan(i_ctr[15:8], i_up[15:8], i_dn[15:8],
                                     i_lf[15:8], i_rgt[15:8], i_s1_ctl.sharpen);
            n_rgb[7:0]   = csbs_chan(i_ctr[7:0], i_up[7:0], i_dn[7:0],
                                     i_lf[7:0], i_rgt[7:0], i_s1_ctl.sharpen);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_out_free) begin
            r_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_out_free && i_s1_valid) begin
            r_rgb       <= n_rgb;
            r_frame_end <= i_s1_ctl.frame_end;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_rgb   = r_rgb;
    assign o_frame_end = r_frame_end;

endmodule

/* sv/cross_stencil_blur_sharpen_core.sv */
// Top level of the five-point cross blur and sharpen filter over a raster RGB stream.
// One pixel or flush transfer is taken per clock. A result passes from the transfer that causes it
// through the registered read of the history memories and then the arithmetic into the output
// register. The history is two single-write, dual-read memories of 2*MAX_WIDTH+1 entries (one of
// single pixels, one of adjacent pixel pairs), which supply the five neighbours in a single read.
// After a write to image_width the input stalls while a serial remainder unit recomputes the
// column of the next result. Apart from that, only a stalled output holds the input back, and
// then only once a second result is waiting behind the output register.
module cross_stencil_blur_sharpen_core #(
    parameter int MAX_WIDTH  = csbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = csbs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [csbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [csbs_pkg::DIM_W-1:0]        i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_action,
    input  logic [csbs_pkg::PIX_W-1:0]        i_pixel_rgb,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [csbs_pkg::PIX_W-1:0]        o_out_rgb,
    output logic                              o_frame_end
);
    import csbs_pkg::*;

    localparam int AW = $clog2(2 * MAX_WIDTH + 1);

    logic               accept;
    logic               out_free;
    logic               s1_valid;
    t_emit_ctl          s1_ctl;
    logic               wr_en;
    logic               rd_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      up_addr;
    logic [AW-1:0]      dn_addr;
    logic [AW-1:0]      ctr_addr;
    logic [AW-1:0]      rgt_addr;
    logic [PIX_W-1:0]   up_px;
    logic [PIX_W-1:0]   dn_px;
    logic [PIX_W-1:0]   lf_px;
    logic [PIX_W-1:0]   ctr_px;
    logic [PIX_W-1:0]   rgt_px;

    assign accept   = i_valid && !o_stall;
    assign out_free = !o_valid || !i_stall;

    csbs_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_action    (i_action),
        .i_out_free  (out_free),
        .o_stall     (o_stall),
        .o_s1_valid  (s1_valid),
        .o_s1_ctl    (s1_ctl),
        .o_wr_en     (wr_en),
        .o_rd_en     (rd_en),
        .o_wr_addr   (wr_addr),
        .o_up_addr   (up_addr),
        .o_dn_addr   (dn_addr),
        .o_ctr_addr  (ctr_addr),
        .o_rgt_addr  (rgt_addr)
    );

    csbs_hist #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_hist (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_px    (i_pixel_rgb),
        .i_rd_en    (rd_en),
        .i_up_addr  (up_addr),
        .i_dn_addr  (dn_addr),
        .i_ctr_addr (ctr_addr),
        .i_rgt_addr (rgt_addr),
        .o_up       (up_px),
        .o_dn       (dn_px),
        .o_lf       (lf_px),
        .o_ctr      (ctr_px),
        .o_rgt      (rgt_px)
    );

    csbs_alu u_alu (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (s1_valid),
        .i_s1_ctl    (s1_ctl),
        .i_up        (up_px),
        .i_dn        (dn_px),
        .i_lf        (lf_px),
        .i_ctr       (ctr_px),
        .i_rgt       (rgt_px),
        .i_out_free  (out_free),
        .o_valid     (o_valid),
        .o_out_rgb   (o_out_rgb),
        .o_frame_end (o_frame_end)
    );

endmodule
